// ===== rtl/mvw_pkg.sv =====
// Shared types and constants for the mesh vertex weld block.
// Beat payloads, operation and status codes, controller states and the
// command and status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package mvw_pkg;

  localparam int COORD_W  = 16;
  localparam int CORNER_W = 10;
  localparam int IDX_W    = 11;
  localparam int DIST_W   = 36;

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_LOAD  = 2'd1,
    ACT_MERGE = 2'd2,
    ACT_REMAP = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_FULL      = 2'd1,
    STS_NOT_FOUND = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_MERGE_DONE,
    ST_REMAP_DONE
  } state_t;

  typedef struct packed {
    action_t                     action;
    logic signed [COORD_W-1:0]   coord_x;
    logic signed [COORD_W-1:0]   coord_y;
    logic signed [COORD_W-1:0]   coord_z;
    logic        [CORNER_W-1:0]  corner_vertex;
  } in_beat_t;

  typedef struct packed {
    logic [IDX_W-1:0] welded_index;
    logic             appended;
    status_t          status;
  } out_beat_t;

  typedef struct packed {
    logic [DIST_W-1:0] weld_distance_sq;
  } cfg_beat_t;

  // Controller to datapath.
  typedef struct packed {
    logic accept;
    logic scan_init;
    logic scan_issue;
    logic map_read;
    logic merge_done;
    logic remap_done;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    action_t action;
    logic    out_free;
    logic    base_empty;
    logic    merge_full;
    logic    remap_hit;
    logic    scan_last;
    logic    pipe_busy;
  } dp_sts_t;

endpackage

// ===== rtl/mvw_if.sv =====
// Valid/ready channel interfaces for the mesh vertex weld block:
// input items, result items and the configuration write. Uses mvw_pkg.
`timescale 1ns / 1ps

interface mvw_in_if;
  logic             valid;
  logic             ready;
  mvw_pkg::in_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mvw_out_if;
  logic               valid;
  logic               ready;
  mvw_pkg::out_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mvw_cfg_if;
  logic               valid;
  logic               ready;
  mvw_pkg::cfg_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/mvw_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module mvw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/mvw_datapath.sv =====
// Datapath of the mesh vertex weld block: vertex and map RAMs, counts,
// the distance pipeline with best-match tracking, and the result register.
// Depends on mvw_pkg and mvw_ram.
`timescale 1ns / 1ps

module mvw_datapath #(
  parameter int MAX_VERTS  = 1024,
  parameter int COORD_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  mvw_pkg::in_beat_t  in_data,
  input  logic               cfg_fire,
  input  mvw_pkg::cfg_beat_t cfg_data,
  input  mvw_pkg::dp_cmd_t   cmd,
  output mvw_pkg::dp_sts_t   sts,
  output logic               out_valid,
  input  logic               out_ready,
  output mvw_pkg::out_beat_t out_data
);
  import mvw_pkg::*;

  localparam int AW       = $clog2(MAX_VERTS);
  localparam int CNT_W    = $clog2(MAX_VERTS + 1);
  localparam int RAW_W    = (COORD_BITS > COORD_W) ? COORD_BITS : COORD_W;
  localparam int VW       = 3 * COORD_BITS;
  localparam int SQ_W     = 2 * COORD_BITS;
  localparam int SUM_W    = SQ_W + 2;
  localparam int DW       = (SUM_W > DIST_W) ? SUM_W : DIST_W;
  localparam int CV_W     = (AW > CORNER_W) ? AW : CORNER_W;
  localparam int CMP_W    = (CV_W > CNT_W) ? CV_W : CNT_W;

  // Input coordinates reduced to COORD_BITS two's complement.
  logic signed [RAW_W-1:0]      raw_x, raw_y, raw_z;
  logic signed [COORD_BITS-1:0] cx, cy, cz;
  logic signed [COORD_BITS-1:0] cx_r, cy_r, cz_r;

  assign raw_x = RAW_W'(in_data.coord_x);
  assign raw_y = RAW_W'(in_data.coord_y);
  assign raw_z = RAW_W'(in_data.coord_z);
  assign cx    = raw_x[COORD_BITS-1:0];
  assign cy    = raw_y[COORD_BITS-1:0];
  assign cz    = raw_z[COORD_BITS-1:0];

  logic [DIST_W-1:0] weld_r;
  logic [CNT_W-1:0]  base_count_r, merge_count_r, app_count_r;
  logic              base_full, merge_full, remap_hit;
  logic [CV_W-1:0]   corner_ext;

  assign base_full  = (base_count_r == CNT_W'(MAX_VERTS));
  assign merge_full = (merge_count_r == CNT_W'(MAX_VERTS));
  assign corner_ext = CV_W'(in_data.corner_vertex);
  assign remap_hit  = (CMP_W'(corner_ext) < CMP_W'(merge_count_r));

  // Scan pointer and distance pipeline.
  logic [AW-1:0]         scan_ptr_r;
  logic                  v_rd_r, v_df_r, v_sq_r;
  logic [AW-1:0]         tag_rd_r, tag_df_r, tag_sq_r;
  logic [VW-1:0]         vert_rd;
  logic signed [COORD_BITS-1:0] vx, vy, vz;
  logic signed [COORD_BITS:0]   dx, dy, dz;
  logic [COORD_BITS:0]          ax, ay, az;
  logic [COORD_BITS-1:0]        mag_x_r, mag_y_r, mag_z_r;
  logic [SQ_W-1:0]              sq_x_r, sq_y_r, sq_z_r;
  logic [SUM_W-1:0]             dist_sum;
  logic [DW-1:0]                best_r;
  logic                         found_r;
  logic [AW-1:0]                hit_r;
  logic                         closer;

  mvw_ram #(
    .WIDTH (VW),
    .DEPTH (MAX_VERTS)
  ) u_vert_ram (
    .clk     (clk),
    .wr_en   (cmd.accept && (in_data.action == ACT_LOAD) && !base_full),
    .wr_addr (base_count_r[AW-1:0]),
    .wr_data ({cx, cy, cz}),
    .rd_en   (cmd.scan_issue),
    .rd_addr (scan_ptr_r),
    .rd_data (vert_rd)
  );

  assign vx = vert_rd[VW-1 -: COORD_BITS];
  assign vy = vert_rd[SQ_W-1 -: COORD_BITS];
  assign vz = vert_rd[COORD_BITS-1:0];

  // The difference of two COORD_BITS values has a magnitude that fits COORD_BITS.
  assign dx = (COORD_BITS+1)'(vx) - (COORD_BITS+1)'(cx_r);
  assign dy = (COORD_BITS+1)'(vy) - (COORD_BITS+1)'(cy_r);
  assign dz = (COORD_BITS+1)'(vz) - (COORD_BITS+1)'(cz_r);
  assign ax = dx[COORD_BITS] ? (COORD_BITS+1)'(-dx) : (COORD_BITS+1)'(dx);
  assign ay = dy[COORD_BITS] ? (COORD_BITS+1)'(-dy) : (COORD_BITS+1)'(dy);
  assign az = dz[COORD_BITS] ? (COORD_BITS+1)'(-dz) : (COORD_BITS+1)'(dz);

  assign dist_sum = SUM_W'(sq_x_r) + SUM_W'(sq_y_r) + SUM_W'(sq_z_r);
  assign closer   = (DW'(dist_sum) < best_r);

  // Map table.
  logic [IDX_W-1:0] merge_idx;
  logic [IDX_W-1:0] map_rd;

  assign merge_idx = found_r ? IDX_W'(hit_r)
                             : IDX_W'(base_count_r) + IDX_W'(app_count_r);

  mvw_ram #(
    .WIDTH (IDX_W),
    .DEPTH (MAX_VERTS)
  ) u_map_ram (
    .clk     (clk),
    .wr_en   (cmd.merge_done),
    .wr_addr (merge_count_r[AW-1:0]),
    .wr_data (merge_idx),
    .rd_en   (cmd.map_read),
    .rd_addr (corner_ext[AW-1:0]),
    .rd_data (map_rd)
  );

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cx_r <= cx;
      cy_r <= cy;
      cz_r <= cz;
    end
    if (cmd.scan_init) begin
      scan_ptr_r <= '0;
    end else if (cmd.scan_issue) begin
      scan_ptr_r <= scan_ptr_r + AW'(1);
    end
    tag_rd_r <= scan_ptr_r;
    tag_df_r <= tag_rd_r;
    tag_sq_r <= tag_df_r;
    mag_x_r  <= ax[COORD_BITS-1:0];
    mag_y_r  <= ay[COORD_BITS-1:0];
    mag_z_r  <= az[COORD_BITS-1:0];
    sq_x_r   <= SQ_W'(mag_x_r) * SQ_W'(mag_x_r);
    sq_y_r   <= SQ_W'(mag_y_r) * SQ_W'(mag_y_r);
    sq_z_r   <= SQ_W'(mag_z_r) * SQ_W'(mag_z_r);
    if (cmd.scan_init) begin
      best_r  <= DW'(weld_r);
      found_r <= 1'b0;
      hit_r   <= '0;
    end else if (v_sq_r && closer) begin
      best_r  <= DW'(dist_sum);
      found_r <= 1'b1;
      hit_r   <= tag_sq_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_rd_r <= 1'b0;
      v_df_r <= 1'b0;
      v_sq_r <= 1'b0;
    end else begin
      v_rd_r <= cmd.scan_issue;
      v_df_r <= v_rd_r;
      v_sq_r <= v_df_r;
    end
  end

  // Counts and the configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weld_r        <= '0;
      base_count_r  <= '0;
      merge_count_r <= '0;
      app_count_r   <= '0;
    end else begin
      if (cfg_fire) begin
        weld_r <= cfg_data.weld_distance_sq;
      end
      if (cmd.accept && (in_data.action == ACT_CLEAR)) begin
        base_count_r  <= '0;
        merge_count_r <= '0;
        app_count_r   <= '0;
      end else if (cmd.accept && (in_data.action == ACT_LOAD) && !base_full) begin
        base_count_r <= base_count_r + CNT_W'(1);
      end else if (cmd.merge_done) begin
        merge_count_r <= merge_count_r + CNT_W'(1);
        if (!found_r) begin
          app_count_r <= app_count_r + CNT_W'(1);
        end
      end
    end
  end

  // Result register. Items that need no search load it in their accept cycle.
  logic      out_valid_r;
  out_beat_t out_r;
  out_beat_t direct_beat;
  logic      direct_load;

  always_comb begin
    direct_beat = '{welded_index: '0, appended: 1'b0, status: STS_OK};
    direct_load = 1'b0;
    unique case (in_data.action)
      ACT_CLEAR: begin
        direct_load = 1'b1;
      end
      ACT_LOAD: begin
        direct_load = 1'b1;
        if (base_full) begin
          direct_beat.status = STS_FULL;
        end else begin
          direct_beat.welded_index = IDX_W'(base_count_r);
        end
      end
      ACT_MERGE: begin
        direct_load        = merge_full;
        direct_beat.status = STS_FULL;
      end
      ACT_REMAP: begin
        direct_load        = !remap_hit;
        direct_beat.status = STS_NOT_FOUND;
      end
      default: begin
        direct_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((cmd.accept && direct_load) || cmd.merge_done || cmd.remap_done) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && direct_load) begin
      out_r <= direct_beat;
    end else if (cmd.merge_done) begin
      out_r <= '{welded_index: merge_idx, appended: !found_r, status: STS_OK};
    end else if (cmd.remap_done) begin
      out_r <= '{welded_index: map_rd, appended: 1'b0, status: STS_OK};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign sts.action     = in_data.action;
  assign sts.out_free   = !out_valid_r || out_ready;
  assign sts.base_empty = (base_count_r == '0);
  assign sts.merge_full = merge_full;
  assign sts.remap_hit  = remap_hit;
  assign sts.scan_last  = ((CNT_W'(scan_ptr_r) + CNT_W'(1)) == base_count_r);
  assign sts.pipe_busy  = v_rd_r || v_df_r || v_sq_r;

endmodule

// ===== rtl/mvw_ctrl.sv =====
// Controller of the mesh vertex weld block: sequences accept, the base
// vertex scan, pipeline drain and the result hand-off. Depends on mvw_pkg.
`timescale 1ns / 1ps

module mvw_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  mvw_pkg::dp_sts_t sts,
  output mvw_pkg::dp_cmd_t cmd
);
  import mvw_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = sts.out_free;
        if (in_valid && sts.out_free) begin
          cmd.accept = 1'b1;
          if ((sts.action == ACT_MERGE) && !sts.merge_full) begin
            cmd.scan_init = 1'b1;
            state_nxt     = sts.base_empty ? ST_MERGE_DONE : ST_SCAN;
          end else if ((sts.action == ACT_REMAP) && sts.remap_hit) begin
            cmd.map_read = 1'b1;
            state_nxt    = ST_REMAP_DONE;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan_issue = 1'b1;
        if (sts.scan_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!sts.pipe_busy) begin
          state_nxt = ST_MERGE_DONE;
        end
      end
      ST_MERGE_DONE: begin
        if (sts.out_free) begin
          cmd.merge_done = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      ST_REMAP_DONE: begin
        if (sts.out_free) begin
          cmd.remap_done = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/mesh_vertex_weld.sv =====
// Top level of the mesh vertex weld block: controller, datapath and ports.
// Depends on mvw_pkg, mvw_if, mvw_ram, mvw_datapath and mvw_ctrl.
`timescale 1ns / 1ps

// Usage. Items arrive on in_ch (valid/ready); each one gives exactly one result
// beat on out_ch. cfg_ch writes the squared weld distance and is always ready;
// write it only while the block is idle.
// Clear, load, a merge into a full map and a remap of an unmapped number
// answer in the cycle after the input beat is accepted. A remap that hits
// reads the map RAM and answers once the remap-done state writes the result.
// A merge streams every stored base vertex through the distance pipeline,
// one vertex per cycle from the single read port of the vertex RAM, so it
// answers after the scan, the pipeline drain and the merge-done state (with
// an empty base it skips scan and drain). One item is worked on at a time;
// the next beat is taken once the controller is back in idle and the output
// register is empty or being read in that same cycle.
// When the receiver stalls, the result is held in the output register and a
// finished merge or remap waits for the register to free up.
// Reset clears the counts, the weld distance and all control state. The vertex
// and map RAMs are not cleared; only entries below the counts are ever read.
module mesh_vertex_weld #(
  parameter int MAX_VERTS  = 1024,
  parameter int COORD_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  mvw_in_if.sink     in_ch,
  mvw_out_if.source  out_ch,
  mvw_cfg_if.sink    cfg_ch
);
  import mvw_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    in_rdy;

  assign in_ch.ready  = in_rdy;
  assign cfg_ch.ready = 1'b1;

  mvw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_rdy),
    .sts      (sts),
    .cmd      (cmd)
  );

  mvw_datapath #(
    .MAX_VERTS  (MAX_VERTS),
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_ch.data),
    .cfg_fire  (cfg_ch.valid && cfg_ch.ready),
    .cfg_data  (cfg_ch.data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data)
  );

  // No new item while the scan is issuing reads.
  a_no_accept_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_issue |-> !in_ch.ready)
    else $error("input ready during vertex scan");

  // No new item while distances are still in flight.
  a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    sts.pipe_busy |-> !in_ch.ready)
    else $error("input ready while distance pipeline busy");

  // A finished merge or remap only writes a free result register.
  a_done_needs_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.merge_done || cmd.remap_done) |-> sts.out_free)
    else $error("result written into an occupied output register");

  // A clear beat answers in the next cycle.
  a_clear_answers: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && (in_ch.data.action == ACT_CLEAR)) |=> out_ch.valid)
    else $error("clear beat gave no result");

endmodule

// ===== bench/weld_checker.sv =====
// Scoreboard for the mesh vertex weld block: watches the input, result and
// distance-write channels, predicts every result and compares it in order.
// Depends on mvw_pkg only; it is instantiated by bench/testbench.sv.
`timescale 1ns / 1ps

module weld_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  mvw_pkg::in_beat_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  mvw_pkg::out_beat_t out_data,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  mvw_pkg::cfg_beat_t cfg_data,
  output int                 fail_count,
  output int                 pending
);
  import mvw_pkg::*;

  localparam int VERTS = 1024;

  logic signed [COORD_W-1:0] base_x [VERTS];
  logic signed [COORD_W-1:0] base_y [VERTS];
  logic signed [COORD_W-1:0] base_z [VERTS];
  logic [IDX_W-1:0]          weld_map [VERTS];
  int                        base_count;
  int                        merge_count;
  int                        appended_count;
  logic [DIST_W-1:0]         weld_sq;
  out_beat_t                 expected_answers [$];
  out_beat_t                 want;

  // Works out the answer to one accepted beat and advances the mesh state.
  function automatic out_beat_t weld_answer(input in_beat_t b);
    out_beat_t        r;
    longint           dx;
    longint           dy;
    longint           dz;
    longint unsigned  dist_sq;
    longint unsigned  best;
    bit               found;
    int               hit;
    r.welded_index = '0;
    r.appended     = 1'b0;
    r.status       = STS_OK;
    case (b.action)
      ACT_CLEAR: begin
        base_count     = 0;
        merge_count    = 0;
        appended_count = 0;
      end
      ACT_LOAD: begin
        if (base_count >= VERTS) begin
          r.status = STS_FULL;
        end else begin
          base_x[base_count] = b.coord_x;
          base_y[base_count] = b.coord_y;
          base_z[base_count] = b.coord_z;
          r.welded_index     = IDX_W'(base_count);
          base_count++;
        end
      end
      ACT_MERGE: begin
        if (merge_count >= VERTS) begin
          r.status = STS_FULL;
        end else begin
          best  = longint'(weld_sq);
          found = 1'b0;
          hit   = 0;
          for (int i = 0; i < base_count; i++) begin
            dx      = longint'(base_x[i]) - longint'(b.coord_x);
            dy      = longint'(base_y[i]) - longint'(b.coord_y);
            dz      = longint'(base_z[i]) - longint'(b.coord_z);
            dist_sq = dx * dx + dy * dy + dz * dz;
            // Strictly closer only, so the first of equal candidates stays.
            if (dist_sq < best) begin
              best  = dist_sq;
              hit   = i;
              found = 1'b1;
            end
          end
          if (found) begin
            r.welded_index = IDX_W'(hit);
          end else begin
            r.welded_index = IDX_W'(base_count + appended_count);
            r.appended     = 1'b1;
            appended_count++;
          end
          weld_map[merge_count] = r.welded_index;
          merge_count++;
        end
      end
      default: begin
        if (int'(b.corner_vertex) < merge_count) begin
          r.welded_index = weld_map[b.corner_vertex];
        end else begin
          r.status = STS_NOT_FOUND;
        end
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input out_beat_t exp_beat,
                                 input out_beat_t got);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%0t: %s: expected idx %0d app %0d sts %0d, got idx %0d app %0d sts %0d",
               $time, what, exp_beat.welded_index, exp_beat.appended, exp_beat.status,
               got.welded_index, got.appended, got.status);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      base_count     = 0;
      merge_count    = 0;
      appended_count = 0;
      weld_sq        = '0;
      fail_count     = 0;
      expected_answers.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_answers.size() == 0) begin
          report_mismatch("result beat with nothing outstanding", '0, out_data);
        end else begin
          want = expected_answers.pop_front();
          if (out_data !== want) begin
            report_mismatch("result mismatch", want, out_data);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        weld_sq = cfg_data.weld_distance_sq;
      end
      if (in_valid && in_ready) begin
        expected_answers.push_back(weld_answer(in_data));
      end
    end
    pending = expected_answers.size();
  end

endmodule

// ===== bench/testbench.sv =====
// Top of the mesh vertex weld bench: clock, reset, stimulus and verdict.
// Depends on mvw_pkg, mvw_if, the mesh_vertex_weld RTL and weld_checker.
`timescale 1ns / 1ps

module testbench;
  import mvw_pkg::*;

  localparam int                STORE_DEPTH  = 1024;
  localparam int                RANDOM_ITEMS = 540;
  localparam logic [DIST_W-1:0] DIST_MAX     = '1;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  bit   no_idle = 1'b0;
  int   fail_count;
  int   pending;
  int   n_clear, n_load, n_merge, n_remap, n_cfg;
  int   sent_base, sent_merges;
  logic signed [COORD_W-1:0] loaded_x [$];
  logic signed [COORD_W-1:0] loaded_y [$];
  logic signed [COORD_W-1:0] loaded_z [$];

  mvw_in_if  in_ch ();
  mvw_out_if out_ch ();
  mvw_cfg_if cfg_ch ();

  mesh_vertex_weld u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  weld_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_data    (in_ch.data),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_data   (out_ch.data),
    .cfg_valid  (cfg_ch.valid),
    .cfg_ready  (cfg_ch.ready),
    .cfg_data   (cfg_ch.data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #15_000_000;
    $display("FAILURE");
    $finish;
  end

  // Mostly no gap, some short ones and now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      if (no_idle) begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end else begin
        int stall;
        stall = pick_gap();
        if (stall > 0) begin
          out_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  function automatic in_beat_t item(input action_t a, input int x, input int y, input int z,
                                    input int corner);
    in_beat_t b;
    b.action        = a;
    b.coord_x       = x[COORD_W-1:0];
    b.coord_y       = y[COORD_W-1:0];
    b.coord_z       = z[COORD_W-1:0];
    b.corner_vertex = corner[CORNER_W-1:0];
    return b;
  endfunction

  function automatic int rnd_coord();
    return $urandom_range(0, 65535);
  endfunction

  // Sends one beat after a random gap and keeps the bench's view of the counts.
  task automatic send_item(input in_beat_t b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.data  <= b;
    in_ch.valid <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    case (b.action)
      ACT_CLEAR: begin
        n_clear++;
        sent_base   = 0;
        sent_merges = 0;
        loaded_x.delete();
        loaded_y.delete();
        loaded_z.delete();
      end
      ACT_LOAD: begin
        n_load++;
        if (sent_base < STORE_DEPTH) begin
          sent_base++;
          loaded_x.push_back(b.coord_x);
          loaded_y.push_back(b.coord_y);
          loaded_z.push_back(b.coord_z);
        end
      end
      ACT_MERGE: begin
        n_merge++;
        if (sent_merges < STORE_DEPTH) sent_merges++;
      end
      default: n_remap++;
    endcase
  endtask

  // Drops valid right after the last accepted beat and waits for every answer.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  task automatic set_weld(input logic [DIST_W-1:0] v);
    cfg_ch.data  <= v;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    n_cfg++;
  endtask

  function automatic logic [DIST_W-1:0] pick_weld(input int phase);
    int r;
    r = $urandom_range(0, 9);
    if (phase % 6 == 0) return '0;
    if (phase % 6 == 1) return DIST_MAX;
    if (r < 2) return {4'($urandom_range(0, 15)), 32'($urandom)};
    if (r < 4) return DIST_W'($urandom_range(0, 20000));
    return DIST_W'($urandom_range(0, 2_000_000));
  endfunction

  // A merge coordinate near a stored vertex, with a small or a wider offset.
  function automatic in_beat_t near_merge();
    int k;
    int spread;
    k      = $urandom_range(0, loaded_x.size() - 1);
    spread = ($urandom_range(0, 3) == 0) ? 8 : 600;
    return item(ACT_MERGE,
                int'(loaded_x[k]) + int'($urandom_range(0, 2 * spread)) - spread,
                int'(loaded_y[k]) + int'($urandom_range(0, 2 * spread)) - spread,
                int'(loaded_z[k]) + int'($urandom_range(0, 2 * spread)) - spread,
                $urandom_range(0, 1023));
  endfunction

  initial begin
    int n_random;
    int phase;
    int n_ops;
    int r;
    int corner;
    int cx, cy, cz;
    int guard;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, starting from the reset distance of zero.
    send_item(item(ACT_REMAP, 0, 0, 0, 0));
    send_item(item(ACT_MERGE, 0, 0, 0, 0));
    send_item(item(ACT_LOAD, 0, 0, 0, 0));
    send_item(item(ACT_MERGE, 0, 0, 0, 0));
    wait_idle();
    set_weld(DIST_W'(65536));
    send_item(item(ACT_LOAD, 0, 0, 0, 0));
    // Exactly at the weld distance must not weld; one step closer ties two copies.
    send_item(item(ACT_MERGE, 256, 0, 0, 0));
    send_item(item(ACT_MERGE, 0, -255, 0, 0));
    send_item(item(ACT_LOAD, 32767, 32767, 32767, 1023));
    send_item(item(ACT_LOAD, -32768, -32768, -32768, 1023));
    wait_idle();
    set_weld(DIST_MAX);
    send_item(item(ACT_MERGE, 32767, -32768, 32767, 0));
    send_item(item(ACT_MERGE, -32768, -32768, -32767, 0));
    send_item(item(ACT_REMAP, 0, 0, 0, 1));
    send_item(item(ACT_REMAP, 0, 0, 0, 4));
    send_item(item(ACT_REMAP, -1, -1, -1, 1023));
    send_item(item(ACT_CLEAR, -1, -1, -1, 1023));
    send_item(item(ACT_REMAP, 0, 0, 0, 0));
    send_item(item(ACT_LOAD, -1, -1, -1, 0));

    // Random phases: a fresh distance, a small base, then mixed traffic.
    n_random = 0;
    phase    = 0;
    while (n_random < RANDOM_ITEMS) begin
      wait_idle();
      set_weld(pick_weld(phase));
      phase++;
      no_idle = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 7) != 0 || sent_base > 200 || sent_merges > 900) begin
        send_item(item(ACT_CLEAR, rnd_coord(), rnd_coord(), rnd_coord(),
                       $urandom_range(0, 1023)));
        n_random++;
      end
      cx = $urandom_range(0, 4095) - 2048;
      cy = $urandom_range(0, 4095) - 2048;
      cz = $urandom_range(0, 4095) - 2048;
      repeat ($urandom_range(0, 40)) begin
        if ($urandom_range(0, 5) == 0) begin
          send_item(item(ACT_LOAD, rnd_coord(), rnd_coord(), rnd_coord(),
                         $urandom_range(0, 1023)));
        end else begin
          send_item(item(ACT_LOAD, cx + $urandom_range(0, 4095) - 2048,
                         cy + $urandom_range(0, 4095) - 2048,
                         cz + $urandom_range(0, 4095) - 2048, $urandom_range(0, 1023)));
        end
        n_random++;
      end
      n_ops = $urandom_range(5, 30);
      repeat (n_ops) begin
        r = $urandom_range(0, 99);
        if (r < 50) begin
          if (loaded_x.size() > 0 && $urandom_range(0, 9) < 7) begin
            send_item(near_merge());
          end else begin
            send_item(item(ACT_MERGE, cx + $urandom_range(0, 4095) - 2048,
                           cy + $urandom_range(0, 4095) - 2048,
                           cz + $urandom_range(0, 4095) - 2048, $urandom_range(0, 1023)));
          end
        end else if (r < 78) begin
          if (sent_merges > 0 && $urandom_range(0, 9) < 8) begin
            corner = $urandom_range(0, sent_merges - 1);
          end else begin
            corner = $urandom_range(0, 1023);
          end
          send_item(item(ACT_REMAP, rnd_coord(), rnd_coord(), rnd_coord(), corner));
        end else if (r < 88) begin
          send_item(item(ACT_LOAD, cx + $urandom_range(0, 1023) - 512,
                         cy + $urandom_range(0, 1023) - 512,
                         cz + $urandom_range(0, 1023) - 512, $urandom_range(0, 1023)));
        end else if (r < 92) begin
          send_item(item(ACT_CLEAR, rnd_coord(), rnd_coord(), rnd_coord(),
                         $urandom_range(0, 1023)));
        end else begin
          // Noise: any operation with arbitrary fields.
          send_item(item(action_t'($urandom_range(0, 3)), rnd_coord(), rnd_coord(),
                         rnd_coord(), $urandom_range(0, 1023)));
        end
        n_random++;
      end
    end

    in_ch.valid <= 1'b0;
    guard = 0;
    while (pending != 0 && guard < 50000) begin
      @(negedge clk);
      guard++;
    end
    repeat (16) @(posedge clk);
    if (pending != 0) $display("%0d results never arrived", pending);
    $display("Covered %0d clears, %0d loads, %0d merges and %0d remaps",
             n_clear, n_load, n_merge, n_remap);
    $display("over %0d distance settings, with exact-threshold ties and extreme coordinates.",
             n_cfg);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
